[rtl/pnev_pkg.sv]
// shared constants, permutation table and gradient functions for the noise evaluator
// no dependencies
`timescale 1ns / 1ps

package pnev_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VAL_W = 20;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [16:0] SCALE_097 = 17'd63570;

  localparam logic [1:0] DIM_1D = 2'd1;
  localparam logic [1:0] DIM_2D = 2'd2;
  localparam logic [1:0] DIM_3D = 2'd3;

  localparam logic signed [1:0] GP = 2'sb01;
  localparam logic signed [1:0] GZ = 2'sb00;
  localparam logic signed [1:0] GN = 2'sb11;

  localparam logic [7:0] PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13,
    8'd201, 8'd95, 8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225,
    8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
    8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148,
    8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
    8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
    8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87,
    8'd174, 8'd20, 8'd125, 8'd136, 8'd171, 8'd168, 8'd68, 8'd175,
    8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
    8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
    8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41,
    8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54,
    8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73,
    8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89, 8'd18, 8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64,
    8'd52, 8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202,
    8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
    8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17,
    8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9,
    8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110,
    8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241,
    8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
    8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121, 8'd50, 8'd45,
    8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141,
    8'd128, 8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
  };

  localparam logic signed [4:0] SCALE1D [16] = '{
    -5'sd8, -5'sd7, -5'sd6, -5'sd5, -5'sd4, -5'sd3, -5'sd2, -5'sd1,
    5'sd1, 5'sd2, 5'sd3, 5'sd4, 5'sd5, 5'sd6, 5'sd7, 5'sd8
  };

  localparam logic signed [1:0] G2X [8] = '{GP, GP, GZ, GN, GN, GN, GZ, GP};
  localparam logic signed [1:0] G2Y [8] = '{GZ, GP, GP, GP, GZ, GN, GN, GN};

  localparam logic signed [1:0] G3X [16] = '{GP, GP, GZ, GN, GN, GN, GZ, GP,
                                             GP, GZ, GN, GZ, GP, GN, GZ, GZ};
  localparam logic signed [1:0] G3Y [16] = '{GZ, GP, GP, GP, GZ, GN, GN, GN,
                                             GZ, GP, GZ, GN, GP, GP, GN, GN};
  localparam logic signed [1:0] G3Z [16] = '{GP, GZ, GP, GZ, GP, GZ, GP, GZ,
                                             GN, GN, GN, GN, GZ, GZ, GP, GN};

  function automatic logic signed [VAL_W-1:0] csel(logic signed [1:0] c,
                                                   logic signed [17:0] v);
    logic signed [VAL_W-1:0] r;
    case (c)
      GP: r = VAL_W'(v);
      GN: r = -VAL_W'(v);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] grad1(logic [7:0] h, logic signed [17:0] x);
    logic signed [22:0] p;
    p = x * SCALE1D[h[3:0]];
    return VAL_W'(p >>> 3);
  endfunction

  function automatic logic signed [VAL_W-1:0] grad2(logic [7:0] h, logic signed [17:0] x,
                                                    logic signed [17:0] y);
    return csel(G2X[h[2:0]], x) + csel(G2Y[h[2:0]], y);
  endfunction

  function automatic logic signed [VAL_W-1:0] grad3(logic [7:0] h, logic signed [17:0] x,
                                                    logic signed [17:0] y,
                                                    logic signed [17:0] z);
    return csel(G3X[h[3:0]], x) + csel(G3Y[h[3:0]], y) + csel(G3Z[h[3:0]], z);
  endfunction

endpackage

[rtl/pnev_fade.sv]
// quintic fade 6t^5 - 15t^4 + 10t^3 in Q16, three register stages
// uses pnev_pkg
`timescale 1ns / 1ps

module pnev_fade (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] t,
  output logic [16:0] u
);

  logic signed [21:0] a_c;
  logic signed [38:0] ta_p;
  logic [31:0]        tt_p;
  logic [15:0]        tt;
  logic signed [20:0] b1;
  logic [15:0]        t1;
  logic [31:0]        c_p;
  logic [15:0]        c2;
  logic signed [20:0] b2;
  logic signed [38:0] u_p;
  logic signed [22:0] u_s;

  assign a_c  = $signed({6'b0, t} * 22'd6) - 22'sd983040;
  assign ta_p = $signed({1'b0, t}) * a_c;
  assign tt_p = t * t;
  assign c_p  = tt * t1;
  assign u_p  = $signed({1'b0, c2}) * b2;
  assign u_s  = u_p[38:16];

  always_ff @(posedge clk) begin
    if (en) begin
      tt <= tt_p[31:16];
      b1 <= 21'(ta_p[38:16] + 23'sd655360);
      t1 <= t;
      c2 <= c_p[31:16];
      b2 <= b1;
      if (u_s < 0) begin
        u <= '0;
      end else if (u_s > 23'(pnev_pkg::ONE_Q16)) begin
        u <= pnev_pkg::ONE_Q16;
      end else begin
        u <= u_s[16:0];
      end
    end
  end

endmodule

[rtl/pnev_hash.sv]
// three-level corner hashing through the permutation table, one level per stage
// uses pnev_pkg
`timescale 1ns / 1ps

module pnev_hash (
  input  logic            clk,
  input  logic            en,
  input  logic [7:0]      xi,
  input  logic [7:0]      yi,
  input  logic [7:0]      zi,
  output logic [7:0]      p0,
  output logic [7:0]      p1,
  output logic [3:0][7:0] q,
  output logic [7:0][7:0] r
);

  logic [7:0]      h0, h1, yi1, zi1;
  logic [7:0]      a, b;
  logic [3:0][7:0] q2;
  logic [7:0]      zi2, g0, g1;
  logic [3:0][7:0] s;

  assign a = 8'(h0 + yi1);
  assign b = 8'(h1 + yi1);
  assign s[0] = 8'(q2[0] + zi2);
  assign s[1] = 8'(q2[1] + zi2);
  assign s[2] = 8'(q2[2] + zi2);
  assign s[3] = 8'(q2[3] + zi2);

  always_ff @(posedge clk) begin
    if (en) begin
      h0  <= pnev_pkg::PERM[xi];
      h1  <= pnev_pkg::PERM[8'(xi + 8'd1)];
      yi1 <= yi;
      zi1 <= zi;
      q2[0] <= pnev_pkg::PERM[a];
      q2[1] <= pnev_pkg::PERM[8'(a + 8'd1)];
      q2[2] <= pnev_pkg::PERM[b];
      q2[3] <= pnev_pkg::PERM[8'(b + 8'd1)];
      zi2 <= zi1;
      g0  <= h0;
      g1  <= h1;
      for (int i = 0; i < 4; i++) begin
        r[2*i]   <= pnev_pkg::PERM[s[i]];
        r[2*i+1] <= pnev_pkg::PERM[8'(s[i] + 8'd1)];
      end
      q  <= q2;
      p0 <= g0;
      p1 <= g1;
    end
  end

endmodule

[rtl/pnev_lerp.sv]
// registered linear interpolation a + floor((b - a) * u / 65536)
// uses pnev_pkg
`timescale 1ns / 1ps

module pnev_lerp (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [pnev_pkg::VAL_W-1:0]  a,
  input  logic signed [pnev_pkg::VAL_W-1:0]  b,
  input  logic [16:0]                        u,
  output logic signed [pnev_pkg::VAL_W-1:0]  q
);

  logic signed [pnev_pkg::VAL_W:0]    d;
  logic signed [pnev_pkg::VAL_W+18:0] p;

  assign d = (pnev_pkg::VAL_W+1)'(b) - (pnev_pkg::VAL_W+1)'(a);
  assign p = d * $signed({1'b0, u});

  always_ff @(posedge clk) begin
    if (en) begin
      q <= pnev_pkg::VAL_W'(a + pnev_pkg::VAL_W'(p >>> 16));
    end
  end

endmodule

[rtl/perlin_noise_evaluator_core.sv]
// Gradient-noise evaluator: one point in, one noise sample out, nine pipeline stages.
// A point is taken every cycle that in_stall is low. The stages are the three-level
// permutation hashing in series with the gradient, three interpolation levels, the 0.97
// scaling multiply (3D only) and the output clamp. An output stall while out_valid is
// high freezes the whole pipeline. dim_data is written with dim_we while idle.
// uses pnev_pkg, pnev_hash, pnev_fade, pnev_lerp
`timescale 1ns / 1ps

module perlin_noise_evaluator_core #(
  parameter int FRAC_BITS = pnev_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               dim_we,
  input  logic [1:0]         dim_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] coord_x,
  input  logic signed [23:0] coord_y,
  input  logic signed [23:0] coord_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] noise_value
);

  localparam int VW = pnev_pkg::VAL_W;

  logic [1:0]        dim;
  logic              en;
  logic [9:1]        vld;
  logic [8:1][1:0]   dims;
  logic [2:0][31:0]  ext;
  logic [2:0][7:0]   cidx;
  logic [2:0][15:0]  frac;
  logic [2:0][15:0]  t1, t2, t3;
  logic [2:0][16:0]  uf;
  logic [16:0]       v5, w5, w6;
  logic [7:0]        p0, p1;
  logic [3:0][7:0]   q;
  logic [7:0][7:0]   r;
  logic signed [17:0] x, y, z, xm, ym, zm;
  logic signed [VW-1:0] ga_c [4];
  logic signed [VW-1:0] gb_c [4];
  logic signed [VW-1:0] ga [4];
  logic signed [VW-1:0] gb [4];
  logic signed [VW-1:0] lx [4];
  logic signed [VW-1:0] ly [2];
  logic signed [VW-1:0] lz;
  logic signed [VW-1:0] s8;
  logic signed [VW+16:0] m_p;
  logic [16:0]       uy, uz;
  logic signed [VW:0] dbl;

  assign en        = !(vld[9] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[9];

  assign ext[0] = {{8{coord_x[23]}}, coord_x};
  assign ext[1] = {{8{coord_y[23]}}, coord_y};
  assign ext[2] = {{8{coord_z[23]}}, coord_z};

  for (genvar i = 0; i < 3; i++) begin : g_split
    assign cidx[i] = ext[i][FRAC_BITS+7:FRAC_BITS];
    if (FRAC_BITS >= 16) begin : g_trunc
      assign frac[i] = ext[i][FRAC_BITS-1:FRAC_BITS-16];
    end else begin : g_fill
      assign frac[i] = {ext[i][FRAC_BITS-1:0], (16-FRAC_BITS)'(0)};
    end
    pnev_fade u_fade (.clk(clk), .en(en), .t(t1[i]), .u(uf[i]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dim <= pnev_pkg::DIM_2D;
    end else if (dim_we) begin
      dim <= dim_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[8:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dims <= {dims[7:1], dim};
      t1 <= frac;
      t2 <= t1;
      t3 <= t2;
      v5 <= uf[1];
      w5 <= uf[2];
      w6 <= w5;
    end
  end

  pnev_hash u_hash (
    .clk(clk), .en(en), .xi(cidx[0]), .yi(cidx[1]), .zi(cidx[2]),
    .p0(p0), .p1(p1), .q(q), .r(r)
  );

  // gradient selection per mode
  assign x  = {2'b00, t3[0]};
  assign y  = {2'b00, t3[1]};
  assign z  = {2'b00, t3[2]};
  assign xm = x - 18'sd65536;
  assign ym = y - 18'sd65536;
  assign zm = z - 18'sd65536;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ga_c[i] = '0;
      gb_c[i] = '0;
    end
    case (dims[3])
      pnev_pkg::DIM_2D: begin
        ga_c[0] = pnev_pkg::grad2(q[0], x, y);
        gb_c[0] = pnev_pkg::grad2(q[2], xm, y);
        ga_c[1] = pnev_pkg::grad2(q[1], x, ym);
        gb_c[1] = pnev_pkg::grad2(q[3], xm, ym);
      end
      pnev_pkg::DIM_3D: begin
        ga_c[0] = pnev_pkg::grad3(r[0], x, y, z);
        gb_c[0] = pnev_pkg::grad3(r[4], xm, y, z);
        ga_c[1] = pnev_pkg::grad3(r[2], x, ym, z);
        gb_c[1] = pnev_pkg::grad3(r[6], xm, ym, z);
        ga_c[2] = pnev_pkg::grad3(r[1], x, y, zm);
        gb_c[2] = pnev_pkg::grad3(r[5], xm, y, zm);
        ga_c[3] = pnev_pkg::grad3(r[3], x, ym, zm);
        gb_c[3] = pnev_pkg::grad3(r[7], xm, ym, zm);
      end
      default: begin
        ga_c[0] = pnev_pkg::grad1(p0, x);
        gb_c[0] = pnev_pkg::grad1(p1, xm);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ga <= ga_c;
      gb <= gb_c;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lx
    pnev_lerp u_lx (.clk(clk), .en(en), .a(ga[i]), .b(gb[i]), .u(uf[0]), .q(lx[i]));
  end

  // a zero weight passes the first operand through
  assign uy = (dims[5] == pnev_pkg::DIM_2D || dims[5] == pnev_pkg::DIM_3D) ? v5 : '0;
  assign uz = (dims[6] == pnev_pkg::DIM_3D) ? w6 : '0;

  pnev_lerp u_ly0 (.clk(clk), .en(en), .a(lx[0]), .b(lx[1]), .u(uy), .q(ly[0]));
  pnev_lerp u_ly1 (.clk(clk), .en(en), .a(lx[2]), .b(lx[3]), .u(uy), .q(ly[1]));
  pnev_lerp u_lz  (.clk(clk), .en(en), .a(ly[0]), .b(ly[1]), .u(uz), .q(lz));

  assign m_p = lz * $signed({1'b0, pnev_pkg::SCALE_097});
  assign dbl = (VW+1)'(s8) <<< 1;

  always_ff @(posedge clk) begin
    if (en) begin
      if (dims[7] == pnev_pkg::DIM_3D) begin
        s8 <= VW'(m_p >>> 16);
      end else begin
        s8 <= lz;
      end
      case (dims[8])
        pnev_pkg::DIM_3D: begin
          if (s8 > VW'(65536)) begin
            noise_value <= 18'sd65536;
          end else if (s8 < -VW'(65536)) begin
            noise_value <= -18'sd65536;
          end else begin
            noise_value <= 18'(s8);
          end
        end
        pnev_pkg::DIM_2D: begin
          if (s8 > VW'(131071)) begin
            noise_value <= 18'sd131071;
          end else if (s8 < -VW'(131072)) begin
            noise_value <= -18'sd131072;
          end else begin
            noise_value <= 18'(s8);
          end
        end
        default: begin
          if (dbl > (VW+1)'(131071)) begin
            noise_value <= 18'sd131071;
          end else if (dbl < -(VW+1)'(131072)) begin
            noise_value <= -18'sd131072;
          end else begin
            noise_value <= 18'(dbl);
          end
        end
      endcase
    end
  end

endmodule

[sim/perlin_noise_evaluator_core_test.sv]
// testbench for perlin_noise_evaluator_core: drives points, predicts each noise sample and
// checks the results in order; depends on rtl/pnev_pkg.sv and the core rtl
`timescale 1ns / 1ps

module perlin_noise_evaluator_core_test;

  localparam logic [1:0] DIM_NONE = 2'd0;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PIPE_DRAIN = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic dim_we = 1'b0;
  logic [1:0] dim_data = pnev_pkg::DIM_2D;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] coord_x = '0;
  logic signed [23:0] coord_y = '0;
  logic signed [23:0] coord_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [17:0] noise_value;

  logic [1:0] dim_shadow = pnev_pkg::DIM_2D;
  logic signed [17:0] expected_samples[$];
  int mismatches = 0;
  int cycles = 0;
  int idle_pct = 26;

  perlin_noise_evaluator_core DUT (
    .clk(clk), .rst(rst), .dim_we(dim_we), .dim_data(dim_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // fixed-point helpers
  function automatic longint mul16(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint blend(longint a, longint b, longint u);
    return a + mul16(b - a, u);
  endfunction

  function automatic longint fade(longint t);
    longint a, b, c, u;
    a = 6 * t - 15 * 65536;
    b = mul16(t, a) + 10 * 65536;
    c = mul16(mul16(t, t), t);
    u = mul16(c, b);
    if (u < 0) u = 0;
    if (u > 65536) u = 65536;
    return u;
  endfunction

  function automatic int hash(int i);
    return int'(pnev_pkg::PERM[i & 255]);
  endfunction

  function automatic longint slope1(int h, longint x);
    return (longint'(pnev_pkg::SCALE1D[h & 15]) * x) >>> 3;
  endfunction

  function automatic longint slope2(int h, longint x, longint y);
    return longint'(pnev_pkg::G2X[h & 7]) * x + longint'(pnev_pkg::G2Y[h & 7]) * y;
  endfunction

  function automatic longint slope3(int h, longint x, longint y, longint z);
    return longint'(pnev_pkg::G3X[h & 15]) * x + longint'(pnev_pkg::G3Y[h & 15]) * y +
           longint'(pnev_pkg::G3Z[h & 15]) * z;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [17:0] noise_sample(logic [1:0] dim, logic [23:0] px,
                                                      logic [23:0] py, logic [23:0] pz);
    int xi, yi, zi, a, b, aa, ab, ba, bb;
    longint x, y, z, xm, ym, zm, u, v, w, lo, hi, n0, n1, r;
    xi = px[23:16];
    yi = py[23:16];
    zi = pz[23:16];
    x = px[15:0];
    y = py[15:0];
    z = pz[15:0];
    xm = x - 65536;
    ym = y - 65536;
    zm = z - 65536;
    u = fade(x);
    v = fade(y);
    w = fade(z);
    if (dim == pnev_pkg::DIM_2D) begin
      aa = hash(xi) + yi;
      ba = hash(xi + 1) + yi;
      lo = blend(slope2(hash(aa), x, y), slope2(hash(ba), xm, y), u);
      hi = blend(slope2(hash(aa + 1), x, ym), slope2(hash(ba + 1), xm, ym), u);
      r = clamp(blend(lo, hi, v), -131072, 131071);
    end else if (dim == pnev_pkg::DIM_3D) begin
      a = hash(xi) + yi;
      b = hash(xi + 1) + yi;
      aa = hash(a) + zi;
      ab = hash(a + 1) + zi;
      ba = hash(b) + zi;
      bb = hash(b + 1) + zi;
      n0 = blend(blend(slope3(hash(aa), x, y, z), slope3(hash(ba), xm, y, z), u),
                 blend(slope3(hash(ab), x, ym, z), slope3(hash(bb), xm, ym, z), u), v);
      n1 = blend(blend(slope3(hash(aa + 1), x, y, zm), slope3(hash(ba + 1), xm, y, zm), u),
                 blend(slope3(hash(ab + 1), x, ym, zm), slope3(hash(bb + 1), xm, ym, zm), u),
                 v);
      r = clamp(mul16(blend(n0, n1, w), 63570), -65536, 65536);
    end else begin
      r = clamp(2 * blend(slope1(hash(xi), x), slope1(hash(xi + 1), xm), u), -131072, 131071);
    end
    return r[17:0];
  endfunction

  // output side: random stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %0d", noise_value);
      end else begin
        if (noise_value !== expected_samples[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise_value mismatch: expected %0d actual %0d",
                     expected_samples[0], noise_value);
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_point(input logic [23:0] x, input logic [23:0] y, input logic [23:0] z);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    do @(posedge clk); while (in_stall);
    expected_samples.push_back(noise_sample(dim_shadow, x, y, z));
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    wait (expected_samples.size() == 0);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  task automatic set_dimensions(input logic [1:0] dim);
    drain();
    dim_we <= 1'b1;
    dim_data <= dim;
    @(negedge clk);
    dim_we <= 1'b0;
    dim_shadow = dim;
  endtask

  function automatic logic [23:0] rand_coord();
    // mostly full range, some near cell edges and zero
    case ($urandom_range(3))
      0: return 24'($signed($urandom_range(2047)) - 1024);
      1: return {8'($urandom_range(255)), 16'($urandom_range(3) == 0 ? 0 : 16'hffff)};
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_reset_default;
    send_point(24'h010000, 24'h028000, 24'h0);
    send_point(24'h00_4000, 24'h00_c000, 24'h0);
  endtask

  task automatic test_extremes(input logic [1:0] dim);
    logic [23:0] edges[8];
    edges = '{24'h000000, 24'h7fffff, 24'h800000, 24'hffffff,
              24'h010000, 24'hff0000, 24'h00ffff, 24'h008000};
    set_dimensions(dim);
    for (int i = 0; i < 8; i++)
      send_point(edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]);
  endtask

  task automatic test_random(input logic [1:0] dim, input int count);
    set_dimensions(dim);
    for (int i = 0; i < count; i++) begin
      idle_pct = (i >= count / 3 && i < count / 2) ? 0 : 26;
      if (i == count / 2) drain();
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
    idle_pct = 26;
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_default();
    test_extremes(pnev_pkg::DIM_1D);
    test_extremes(pnev_pkg::DIM_3D);
    test_extremes(DIM_NONE);
    test_random(pnev_pkg::DIM_3D, 500);
    test_random(pnev_pkg::DIM_1D, 400);
    test_random(DIM_NONE, 150);
    test_random(pnev_pkg::DIM_2D, 450);
    test_random(pnev_pkg::DIM_3D, 320);
    drain();
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
